FILE: src/mdsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdsd_pkg
// Shared types and constants of the minimum-distance symbol detector.
// ----------------------------------------------------------------------------
package mdsd_pkg;

  localparam int MaxPointsDef = 16;
  localparam int CfgW         = 5;
  localparam int DistW        = 33;
  localparam int SqW          = 32;

  localparam logic [CfgW-1:0] PointsInUseRst = CfgW'(4);

  localparam logic ReqDetect = 1'b0;
  localparam logic ReqLoad   = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [3:0]         point_index;
    logic signed [15:0] sample_i;
    logic signed [15:0] sample_q;
  } mdsd_in_t;

  typedef struct packed {
    logic signed [15:0] est_i;
    logic signed [15:0] est_q;
    logic [3:0]         est_index;
    logic [DistW-1:0]   min_distance;
  } mdsd_out_t;

  typedef struct packed {
    logic load_wr;
    logic sample_ld;
    logic rd_en;
    logic out_ld;
  } mdsd_cmd_t;

  typedef struct packed {
    logic busy;
  } mdsd_sts_t;

endpackage

FILE: src/mdsd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdsd_datapath
// Reference point table, distance pipeline and running minimum search.
// ----------------------------------------------------------------------------
module mdsd_datapath import mdsd_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDef,
  localparam int AddrW = $clog2(MAX_POINTS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mdsd_in_t         in_data_i,
  input  mdsd_cmd_t        cmd_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output mdsd_sts_t        sts_o,
  output mdsd_out_t        out_data_o
);

  logic [15:0] mem_i [MAX_POINTS];
  logic [15:0] mem_q [MAX_POINTS];

  logic                    wr_ok;
  logic [AddrW-1:0]        wr_addr;

  logic signed [15:0]      smp_i_q, smp_q_q;

  logic                    v1_q, v2_q;
  logic [15:0]             rd_i_q, rd_q_q;
  logic [AddrW-1:0]        idx1_q, idx2_q;

  logic signed [16:0]      diff_i, diff_q;
  logic signed [33:0]      prod_i, prod_q;
  logic [SqW-1:0]          sq_i_q, sq_q_q;
  logic [15:0]             ref_i2_q, ref_q2_q;

  logic [DistW-1:0]        cand_d;
  logic                    take;
  logic [DistW-1:0]        best_d_q;
  logic [AddrW-1:0]        best_idx_q;
  logic [15:0]             best_i_q, best_q_q;

  mdsd_out_t               out_q;

  assign wr_ok   = 32'(in_data_i.point_index) < 32'(MAX_POINTS);
  assign wr_addr = AddrW'(in_data_i.point_index);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && wr_ok) begin
      mem_i[wr_addr] <= in_data_i.sample_i;
      mem_q[wr_addr] <= in_data_i.sample_q;
    end
    if (cmd_i.rd_en) begin
      rd_i_q <= mem_i[rd_addr_i];
      rd_q_q <= mem_q[rd_addr_i];
      idx1_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
    end
  end

  assign diff_i = 17'(signed'(rd_i_q)) - 17'(smp_i_q);
  assign diff_q = 17'(signed'(rd_q_q)) - 17'(smp_q_q);
  assign prod_i = diff_i * diff_i;
  assign prod_q = diff_q * diff_q;

  assign cand_d = DistW'(sq_i_q) + DistW'(sq_q_q);
  assign take   = (idx2_q == '0) || (cand_d < best_d_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_ld) begin
      smp_i_q <= in_data_i.sample_i;
      smp_q_q <= in_data_i.sample_q;
    end
    if (v1_q) begin
      sq_i_q   <= SqW'(prod_i);
      sq_q_q   <= SqW'(prod_q);
      idx2_q   <= idx1_q;
      ref_i2_q <= rd_i_q;
      ref_q2_q <= rd_q_q;
    end
    if (v2_q && take) begin
      best_d_q   <= cand_d;
      best_idx_q <= idx2_q;
      best_i_q   <= ref_i2_q;
      best_q_q   <= ref_q2_q;
    end
    if (cmd_i.out_ld) begin
      out_q.est_i        <= best_i_q;
      out_q.est_q        <= best_q_q;
      out_q.est_index    <= 4'(best_idx_q);
      out_q.min_distance <= best_d_q;
    end
  end

  assign sts_o.busy = v1_q || v2_q;
  assign out_data_o = out_q;

endmodule

FILE: src/mdsd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdsd_ctrl
// Sequencer: request decode, table scan addressing and result handoff.
// ----------------------------------------------------------------------------
module mdsd_ctrl import mdsd_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDef,
  localparam int AddrW = $clog2(MAX_POINTS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             req_type_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  output mdsd_cmd_t        cmd_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  mdsd_sts_t        sts_i
);

  localparam int NBits = $clog2(MAX_POINTS + 1);
  localparam int NW    = (NBits > CfgW) ? NBits : CfgW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e            state_q;
  logic [AddrW-1:0]  cnt_q, last_q;
  logic [AddrW-1:0]  last_d;
  logic              out_valid_q;
  logic [CfgW-1:0]   cfg_q;
  logic [NW-1:0]     n_lim;
  logic              accept, out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    n_lim = (cfg_q == '0) ? NW'(1) : NW'(cfg_q);
    if (n_lim > NW'(MAX_POINTS)) begin
      n_lim = NW'(MAX_POINTS);
    end
    last_d = AddrW'(n_lim - NW'(1));
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign rd_addr_o       = cnt_q;
  assign cmd_o.load_wr   = accept && (req_type_i == ReqLoad);
  assign cmd_o.sample_ld = accept && (req_type_i == ReqDetect);
  assign cmd_o.rd_en     = (state_q == ST_SCAN);
  assign cmd_o.out_ld    = (state_q == ST_DRAIN) && !sts_i.busy && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      cfg_q       <= PointsInUseRst;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && !cmd_o.out_ld) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (req_type_i == ReqDetect)) begin
            cnt_q   <= '0;
            last_q  <= last_d;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt_q <= cnt_q + AddrW'(1);
          if (cnt_q == last_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!sts_i.busy && out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/min_distance_symbol_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_distance_symbol_detector
// Hard-decision detector: nearest reference point by squared distance.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o, in_data_i) carries load and detect
// items. A load writes one reference point into the table in the cycle it is
// accepted; the block is ready again on the next cycle and returns no item.
// A detect scans table entries 0 to N-1, one entry per cycle, where N is the
// points_in_use register (zero counts as one, values above MAX_POINTS clamp).
// The result item appears on out_valid_o/out_data_o after the table reads,
// once the multiply and the compare stages have emptied out. A new item is
// accepted once the result sits in the output register, so a detect never
// overlaps the scan or the pipeline stages of the one before it.
// If the receiver stalls, the result waits in the output register; a
// following detect scans meanwhile and holds its own result until the output
// register frees up. Reset empties the output and sets points_in_use to 4;
// the table is not cleared and must be loaded before use.
// cfg_we_i/cfg_data_i write points_in_use; write it only while idle.
// ----------------------------------------------------------------------------
module min_distance_symbol_detector import mdsd_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mdsd_in_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mdsd_out_t       out_data_o,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam int AddrW = $clog2(MAX_POINTS);

  mdsd_cmd_t        cmd;
  mdsd_sts_t        sts;
  logic [AddrW-1:0] rd_addr;

  mdsd_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (in_data_i.req_type),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .sts_i       (sts)
  );

  mdsd_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .rd_addr_i  (rd_addr),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

FILE: src/mdsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdsd_checker
// Port-level checks of the detector, bound to the top level.
// ----------------------------------------------------------------------------
module mdsd_checker import mdsd_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input mdsd_in_t        in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input mdsd_out_t       out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output item changed");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.req_type == ReqLoad) |=> in_ready_o)
    else $error("load item did not complete in one cycle");

  a_detect_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.req_type == ReqDetect)
      |=> !in_ready_o && !$rose(out_valid_o))
    else $error("detect item did not start a scan");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result item appeared without a scan");

endmodule

bind min_distance_symbol_detector mdsd_checker u_mdsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: bench/tb_min_distance_symbol_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_min_distance_symbol_detector
// Self-checking bench for the minimum-distance symbol detector. A directed
// table of loads, detects and point-count writes runs first, then phases of
// random loads and noisy samples under several point counts. Every result
// item is checked field by field against its stated value or a nearest-point
// predictor, with random idle gaps on input and random stalls on output.
// ----------------------------------------------------------------------------
module tb_min_distance_symbol_detector;
  import mdsd_pkg::*;

  localparam int HalfPeriod    = 10;
  localparam int DrainCycles   = 2 * MaxPointsDef + 8;
  localparam int CycleLimit    = 500000;
  localparam int PhaseCnt      = 10;
  localparam int ItemsPerPhase = 54;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    mdsd_in_t         item;
    bit               typed;
    mdsd_out_t        want;
    logic [CfgW-1:0]  points;
  } stim_row_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  mdsd_in_t        in_data_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  mdsd_out_t       out_data_o;
  logic            cfg_we_i    = 1'b0;
  logic [CfgW-1:0] cfg_data_i  = '0;

  // predictor state
  logic signed [15:0] ref_i_tbl [MaxPointsDef];
  logic signed [15:0] ref_q_tbl [MaxPointsDef];
  bit                 loaded    [MaxPointsDef];
  logic [CfgW-1:0]    points_cfg = PointsInUseRst;

  mdsd_out_t       nearest_q [$];
  mdsd_out_t       want_out;
  stim_row_t       dir_rows [$];
  int              fail_cnt   = 0;
  int              cycle_cnt  = 0;
  int              stall_left = 0;
  bit              steady_rx  = 1'b0;
  bit              steady_tx  = 1'b0;
  logic [CfgW-1:0] point_plan [8] = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd17, 5'd1, 5'd8, 5'd2};

  min_distance_symbol_detector #(
    .MAX_POINTS(MaxPointsDef)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #(HalfPeriod) clk_i = 1'b1;
    #(HalfPeriod) clk_i = 1'b0;
  end

  function automatic int eff_points();
    if (points_cfg == 0) return 1;
    if (points_cfg > MaxPointsDef) return MaxPointsDef;
    return int'(points_cfg);
  endfunction

  function automatic mdsd_out_t nearest_point(logic signed [15:0] si, logic signed [15:0] sq);
    mdsd_out_t res;
    longint    sq_dist;
    longint    best_dist;
    int        best;
    int        di;
    int        dq;
    best      = 0;
    best_dist = 0;
    for (int k = 0; k < eff_points(); k++) begin
      di      = int'(ref_i_tbl[k]) - int'(si);
      dq      = int'(ref_q_tbl[k]) - int'(sq);
      sq_dist = longint'(di) * longint'(di) + longint'(dq) * longint'(dq);
      if (k == 0 || sq_dist < best_dist) begin
        best_dist = sq_dist;
        best      = k;
      end
    end
    res.est_i        = ref_i_tbl[best];
    res.est_q        = ref_q_tbl[best];
    res.est_index    = 4'(best);
    res.min_distance = DistW'(best_dist);
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 18) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      1, 2, 3: return 16'((int'($urandom_range(0, 15)) - 8) * 4096);
      4:       return 16'((int'($urandom_range(0, 15)) - 8) * 4096 + 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic mdsd_in_t random_item();
    mdsd_in_t it;
    int       first_free;
    int       k;
    first_free     = -1;
    it.req_type    = ReqLoad;
    it.point_index = 4'($urandom);
    it.sample_i    = pick_value();
    it.sample_q    = pick_value();
    for (int j = eff_points() - 1; j >= 0; j--) begin
      if (!loaded[j]) first_free = j;
    end
    if (first_free >= 0) begin
      it.point_index = 4'(first_free);
    end else if ($urandom_range(0, 9) < 7) begin
      it.req_type = ReqDetect;
      if ($urandom_range(0, 1) == 1) begin
        k           = $urandom_range(0, eff_points() - 1);
        it.sample_i = 16'(int'(ref_i_tbl[k]) + int'($urandom_range(0, 1024)) - 512);
        it.sample_q = 16'(int'(ref_q_tbl[k]) + int'($urandom_range(0, 1024)) - 512);
      end
    end
    return it;
  endfunction

  function automatic stim_row_t load_row(int idx, int vi, int vq);
    stim_row_t row;
    row.kind                 = RowItem;
    row.item.req_type        = ReqLoad;
    row.item.point_index     = 4'(idx);
    row.item.sample_i        = 16'(vi);
    row.item.sample_q        = 16'(vq);
    row.typed                = 1'b0;
    row.want                 = '0;
    row.points               = '0;
    return row;
  endfunction

  function automatic stim_row_t detect_row(int vi, int vq);
    stim_row_t row;
    row                  = load_row(15, vi, vq);
    row.item.req_type    = ReqDetect;
    return row;
  endfunction

  function automatic stim_row_t expect_row(int vi, int vq, int ei, int eq, int eidx,
                                           logic [DistW-1:0] want_dist);
    stim_row_t row;
    row                   = detect_row(vi, vq);
    row.typed             = 1'b1;
    row.want.est_i        = 16'(ei);
    row.want.est_q        = 16'(eq);
    row.want.est_index    = 4'(eidx);
    row.want.min_distance = want_dist;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(int v);
    stim_row_t row;
    row        = load_row(0, 0, 0);
    row.kind   = RowCfg;
    row.points = CfgW'(v);
    return row;
  endfunction

  function automatic void add_row(stim_row_t row);
    dir_rows = {dir_rows, row};
  endfunction

  task automatic push_item(mdsd_in_t item, bit typed, mdsd_out_t want);
    int        gap;
    mdsd_out_t exp_out;
    if ($urandom_range(0, 49) == 0) steady_tx = !steady_tx;
    gap = (steady_tx || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (item.req_type == ReqLoad) begin
      ref_i_tbl[item.point_index] = item.sample_i;
      ref_q_tbl[item.point_index] = item.sample_q;
      loaded[item.point_index]    = 1'b1;
    end else begin
      exp_out   = typed ? want : nearest_point(item.sample_i, item.sample_q);
      nearest_q = {nearest_q, exp_out};
    end
  endtask

  task automatic write_points(logic [CfgW-1:0] v);
    in_valid_i <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    points_cfg = v;
  endtask

  // output side: random stalls with stretches of steady acceptance
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) steady_rx <= !steady_rx;
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!steady_rx && $urandom_range(0, 3) == 0) stall_left <= idle_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (nearest_q.size() == 0) begin
        $error("result item with nothing expected");
        fail_cnt++;
      end else begin
        want_out = nearest_q.pop_front();
        if (out_data_o.est_i !== want_out.est_i) begin
          $error("est_i: expected %0d, got %0d", want_out.est_i, out_data_o.est_i);
          fail_cnt++;
        end
        if (out_data_o.est_q !== want_out.est_q) begin
          $error("est_q: expected %0d, got %0d", want_out.est_q, out_data_o.est_q);
          fail_cnt++;
        end
        if (out_data_o.est_index !== want_out.est_index) begin
          $error("est_index: expected %0d, got %0d", want_out.est_index,
                 out_data_o.est_index);
          fail_cnt++;
        end
        if (out_data_o.min_distance !== want_out.min_distance) begin
          $error("min_distance: expected %0d, got %0d", want_out.min_distance,
                 out_data_o.min_distance);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < MaxPointsDef; k++) begin
      ref_i_tbl[k] = '0;
      ref_q_tbl[k] = '0;
      loaded[k]    = 1'b0;
    end

    add_row(load_row(0, -32768, -32768));
    add_row(load_row(1, 32767, 32767));
    add_row(load_row(2, 0, 0));
    add_row(load_row(3, 8192, 0));
    add_row(expect_row(-32768, -32768, -32768, -32768, 0, 33'd0));
    add_row(expect_row(32767, 32767, 32767, 32767, 1, 33'd0));
    add_row(expect_row(0, 0, 0, 0, 2, 33'd0));
    // equal distance to entries 2 and 3: lower index wins
    add_row(expect_row(4096, 0, 0, 0, 2, 33'd16777216));
    add_row(detect_row(32767, -32768));
    add_row(detect_row(-1, 1));
    // zero points in use searches entry 0 only
    add_row(cfg_row(0));
    add_row(expect_row(32767, 32767, -32768, -32768, 0, 33'd8589672450));
    add_row(cfg_row(1));
    add_row(expect_row(0, 0, -32768, -32768, 0, 33'd2147483648));
    add_row(cfg_row(2));
    add_row(load_row(1, -32768, -32768));
    add_row(expect_row(-32768, -32768, -32768, -32768, 0, 33'd0));
    add_row(detect_row(100, -100));
    add_row(cfg_row(4));
    add_row(detect_row(4096, 4096));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == RowCfg) begin
        write_points(dir_rows[r].points);
      end else begin
        push_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
      end
    end

    for (int p = 0; p < PhaseCnt; p++) begin
      write_points((p < 8) ? point_plan[p] : CfgW'($urandom_range(0, 31)));
      for (int j = 0; j < ItemsPerPhase; j++) begin
        push_item(random_item(), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
